// ===== rtl/rss_pkg.sv =====
// shared types and constants of the ramp/soak segment sequencer
package rss_pkg;

   typedef enum logic [2:0] {
      KIND_REGISTER   = 3'd0,
      KIND_MODIFY     = 3'd1,
      KIND_DEREGISTER = 3'd2,
      KIND_START      = 3'd3,
      KIND_STOP       = 3'd4,
      KIND_CLEAR      = 3'd5,
      KIND_TICK       = 3'd6,
      KIND_UNUSED     = 3'd7
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_FULL       = 3'd1,
      ST_DUPLICATE  = 3'd2,
      ST_NOT_FOUND  = 3'd3,
      ST_IN_PROGRESS = 3'd4,
      ST_NO_SEGMENTS = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_HOLD   = 3'd1,
      PH_POLL   = 3'd2,
      PH_RAMP   = 3'd3,
      PH_SETTLE = 3'd4
   } phase_type;

   localparam logic [1:0] CSR_DEVIATION = 2'd0;
   localparam logic [1:0] CSR_TOLERANCE = 2'd1;
   localparam logic [1:0] CSR_POLL      = 2'd2;

   localparam logic [14:0] DEVIATION_RESET = 15'd500;
   localparam logic [14:0] TOLERANCE_RESET = 15'd15;
   localparam logic [15:0] POLL_RESET      = 16'd1000;

endpackage

// ===== rtl/ramp_soak_segment_sequencer.sv =====
// top level of the ramp/soak segment sequencer: segment table, chain and profile engine
//
//  channel | ports  | direction | content
//  --------+--------+-----------+----------------------------------------
//  request | req_*  | in        | command or millisecond tick item
//  result  | rsp_*  | out       | one status/setpoint item per request
//  csr     | csr_*  | in        | register index and write data
//
// an item is scanned slot by slot through the single shared id compare (S_SCAN), then
// applied (S_EXEC) and presented as a result (S_RESP) before the return to idle (S_IDLE).
// deregister scans the table a second time to find the predecessor when the id is found.
// clear walks the table one slot a cycle as well. reset is synchronous and clears all
// control state, valid/busy bits and links. ready stays low from acceptance until the
// result item is taken; a stalled result holds and delays the return to idle.
module ramp_soak_segment_sequencer #(
   parameter int SEGMENTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [15:0] req_segment_number,
   input  logic        req_segment_dynamic,
   input  logic signed [15:0] req_start_temp,
   input  logic signed [15:0] req_stop_temp,
   input  logic signed [15:0] req_temp_step,
   input  logic [23:0] req_interval_ms,
   input  logic signed [15:0] req_controller_error,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic signed [15:0] rsp_setpoint,
   output logic        rsp_setpoint_changed,
   output logic        rsp_feedback_mode,
   output logic        rsp_segment_started,
   output logic [15:0] rsp_started_number,
   output logic        rsp_program_done,
   output logic [15:0] rsp_realized_count,
   output logic [15:0] rsp_last_number,
   output logic        rsp_running,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int IW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
   localparam int PW = $clog2(SEGMENTS + 1);
   localparam logic [PW-1:0] NIL = PW'(SEGMENTS);
   localparam logic [PW-1:0] LAST = PW'(SEGMENTS - 1);

   typedef enum logic [1:0] {
      S_IDLE  = 2'd0,
      S_SCAN  = 2'd1,
      S_EXEC  = 2'd2,
      S_RESP  = 2'd3
   } fsm_type;

   // configuration registers
   logic [14:0] dev_ff, tol_ff;
   logic [15:0] poll_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_ff  <= rss_pkg::DEVIATION_RESET;
         tol_ff  <= rss_pkg::TOLERANCE_RESET;
         poll_ff <= rss_pkg::POLL_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            rss_pkg::CSR_DEVIATION: dev_ff  <= csr_data[14:0];
            rss_pkg::CSR_TOLERANCE: tol_ff  <= csr_data[14:0];
            rss_pkg::CSR_POLL:      poll_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // segment table
   logic [SEGMENTS-1:0] valid_ff, busy_ff;
   logic [15:0]        ident_ff  [SEGMENTS];
   logic               dyn_ff    [SEGMENTS];
   logic signed [15:0] start_ff  [SEGMENTS];
   logic signed [15:0] stop_ff   [SEGMENTS];
   logic signed [15:0] step_ff   [SEGMENTS];
   logic [23:0]        period_ff [SEGMENTS];
   logic [PW-1:0]      next_ff   [SEGMENTS];

   logic [PW-1:0] head_ff, tail_ff, used_ff;
   logic [15:0]   done_ff, last_ff;
   rss_pkg::phase_type phase_ff;
   logic signed [15:0] sp_ff;
   logic [23:0]   cnt_ff;
   logic          run_ff, fb_ff;

   // captured item and scan results
   fsm_type       fsm_ff;
   logic [2:0]    kind_ff;
   logic [15:0]   num_ff;
   logic          dyni_ff;
   logic signed [15:0] sti_ff, spi_ff, sti2_ff, err_ff;
   logic [23:0]   ivl_ff;
   logic [PW-1:0] ptr_ff, hit_ff, free_ff, prev_ff;
   logic          pass_ff;

   // result register
   logic [2:0]  o_status_ff;
   logic        o_chg_ff, o_start_ff, o_done_ff;
   logic [15:0] o_snum_ff;

   assign req_ready = (fsm_ff == S_IDLE);
   assign rsp_valid = (fsm_ff == S_RESP);
   assign rsp_status = o_status_ff;
   assign rsp_setpoint = sp_ff;
   assign rsp_setpoint_changed = o_chg_ff;
   assign rsp_feedback_mode = fb_ff;
   assign rsp_segment_started = o_start_ff;
   assign rsp_started_number = o_snum_ff;
   assign rsp_program_done = o_done_ff;
   assign rsp_realized_count = done_ff;
   assign rsp_last_number = last_ff;
   assign rsp_running = run_ff;

   // shared compare unit on the scanned slot
   logic [IW-1:0] pi;
   logic          s_id_hit, s_prev_hit;
   assign pi = ptr_ff[IW-1:0];
   assign s_id_hit = valid_ff[pi] && (ident_ff[pi] == num_ff);
   assign s_prev_hit = valid_ff[pi] && (next_ff[pi] == hit_ff) && (ptr_ff != hit_ff);

   // head slot and tick arithmetic
   logic [IW-1:0] hi;
   logic          hvalid, expired, reached_w;
   logic signed [16:0] sum_w;
   logic signed [15:0] nsp_w;
   assign hi = head_ff[IW-1:0];
   assign hvalid = head_ff < NIL;
   assign expired = (cnt_ff <= 24'd1);
   assign reached_w = (err_ff < $signed({1'b0, tol_ff})) &&
                      (err_ff > -$signed({1'b0, tol_ff}));
   assign sum_w = 17'(sp_ff) + 17'(step_ff[hi]);

   always_comb begin
      nsp_w = sum_w[15:0];
      if ((step_ff[hi] > 0 && sum_w > 17'(stop_ff[hi])) ||
          (step_ff[hi] < 0 && sum_w < 17'(stop_ff[hi])))
         nsp_w = stop_ff[hi];
   end

   // control sequencer, table updates and result register
   always_ff @(posedge clock) begin
      logic [PW-1:0] nh;
      logic          fin;
      logic [23:0]   cn;
      if (reset) begin
         fsm_ff   <= S_IDLE;
         valid_ff <= '0;
         busy_ff  <= '0;
         for (int k = 0; k < SEGMENTS; k++) next_ff[k] <= NIL;
         head_ff  <= NIL;
         tail_ff  <= NIL;
         used_ff  <= '0;
         done_ff  <= '0;
         last_ff  <= '0;
         phase_ff <= rss_pkg::PH_IDLE;
         sp_ff    <= '0;
         cnt_ff   <= '0;
         run_ff   <= 1'b0;
         fb_ff    <= 1'b0;
      end else begin
         unique case (fsm_ff)
            S_IDLE: begin
               if (req_valid) begin
                  kind_ff <= req_kind;
                  num_ff  <= req_segment_number;
                  dyni_ff <= req_segment_dynamic;
                  sti_ff  <= req_start_temp;
                  spi_ff  <= req_stop_temp;
                  sti2_ff <= req_temp_step;
                  ivl_ff  <= req_interval_ms;
                  err_ff  <= req_controller_error;
                  ptr_ff  <= '0;
                  hit_ff  <= NIL;
                  free_ff <= NIL;
                  prev_ff <= NIL;
                  pass_ff <= 1'b0;
                  o_chg_ff <= 1'b0;
                  o_start_ff <= 1'b0;
                  o_done_ff <= 1'b0;
                  o_snum_ff <= '0;
                  o_status_ff <= rss_pkg::ST_OK;
                  fsm_ff <= S_SCAN;
               end
            end
            // walk table: id match, lowest free slot, predecessor on deregister; clear frees slots
            S_SCAN: begin
               if (kind_ff == rss_pkg::KIND_CLEAR) begin
                  valid_ff[pi] <= 1'b0;
                  busy_ff[pi]  <= 1'b0;
                  next_ff[pi]  <= NIL;
               end
               if (!pass_ff) begin
                  if (hit_ff == NIL && s_id_hit) hit_ff <= ptr_ff;
                  if (free_ff == NIL && !valid_ff[pi]) free_ff <= ptr_ff;
               end else if (prev_ff == NIL && s_prev_hit) begin
                  prev_ff <= ptr_ff;
               end
               if (ptr_ff == LAST) begin
                  if (!pass_ff && kind_ff == rss_pkg::KIND_DEREGISTER &&
                      (hit_ff != NIL || s_id_hit)) begin
                     pass_ff <= 1'b1;
                     ptr_ff  <= '0;
                  end else begin
                     fsm_ff <= S_EXEC;
                  end
               end else begin
                  ptr_ff <= ptr_ff + 1'b1;
               end
            end
            S_EXEC: begin
               fsm_ff <= S_RESP;
               unique case (kind_ff)
                  rss_pkg::KIND_REGISTER: begin
                     if (used_ff >= NIL || free_ff == NIL) o_status_ff <= rss_pkg::ST_FULL;
                     else if (hit_ff != NIL) o_status_ff <= rss_pkg::ST_DUPLICATE;
                     else begin
                        valid_ff[free_ff[IW-1:0]]  <= 1'b1;
                        busy_ff[free_ff[IW-1:0]]   <= 1'b0;
                        ident_ff[free_ff[IW-1:0]]  <= num_ff;
                        next_ff[free_ff[IW-1:0]]   <= NIL;
                        dyn_ff[free_ff[IW-1:0]]    <= dyni_ff;
                        start_ff[free_ff[IW-1:0]]  <= sti_ff;
                        stop_ff[free_ff[IW-1:0]]   <= spi_ff;
                        step_ff[free_ff[IW-1:0]]   <= sti2_ff;
                        period_ff[free_ff[IW-1:0]] <= ivl_ff;
                        if (head_ff >= NIL || tail_ff >= NIL) head_ff <= free_ff;
                        else next_ff[tail_ff[IW-1:0]] <= free_ff;
                        tail_ff <= free_ff;
                        used_ff <= used_ff + 1'b1;
                     end
                  end
                  rss_pkg::KIND_MODIFY: begin
                     if (hit_ff == NIL) o_status_ff <= rss_pkg::ST_NOT_FOUND;
                     else if (busy_ff[hit_ff[IW-1:0]]) o_status_ff <= rss_pkg::ST_IN_PROGRESS;
                     else begin
                        dyn_ff[hit_ff[IW-1:0]]    <= dyni_ff;
                        start_ff[hit_ff[IW-1:0]]  <= sti_ff;
                        stop_ff[hit_ff[IW-1:0]]   <= spi_ff;
                        step_ff[hit_ff[IW-1:0]]   <= sti2_ff;
                        period_ff[hit_ff[IW-1:0]] <= ivl_ff;
                     end
                  end
                  rss_pkg::KIND_DEREGISTER: begin
                     if (hit_ff == NIL) o_status_ff <= rss_pkg::ST_NOT_FOUND;
                     else if (busy_ff[hit_ff[IW-1:0]]) o_status_ff <= rss_pkg::ST_IN_PROGRESS;
                     else begin
                        if (prev_ff != NIL) next_ff[prev_ff[IW-1:0]] <= next_ff[hit_ff[IW-1:0]];
                        else if (head_ff == hit_ff) head_ff <= next_ff[hit_ff[IW-1:0]];
                        if (tail_ff == hit_ff) tail_ff <= prev_ff;
                        valid_ff[hit_ff[IW-1:0]] <= 1'b0;
                        next_ff[hit_ff[IW-1:0]]  <= NIL;
                        if (used_ff != '0) used_ff <= used_ff - 1'b1;
                     end
                  end
                  rss_pkg::KIND_START: begin
                     if (!hvalid) o_status_ff <= rss_pkg::ST_NO_SEGMENTS;
                     else if (!run_ff) begin
                        run_ff <= 1'b1;
                        fb_ff  <= 1'b1;
                        busy_ff[hi] <= 1'b1;
                        sp_ff <= start_ff[hi];
                        o_chg_ff <= 1'b1;
                        o_start_ff <= 1'b1;
                        o_snum_ff <= ident_ff[hi];
                        cnt_ff <= period_ff[hi];
                        phase_ff <= dyn_ff[hi] ? rss_pkg::PH_RAMP : rss_pkg::PH_HOLD;
                     end
                  end
                  rss_pkg::KIND_STOP, rss_pkg::KIND_CLEAR: begin
                     if (run_ff) begin
                        run_ff <= 1'b0;
                        if (hvalid && kind_ff == rss_pkg::KIND_STOP) busy_ff[hi] <= 1'b0;
                        fb_ff <= 1'b0;
                        phase_ff <= rss_pkg::PH_IDLE;
                        cnt_ff <= '0;
                     end
                     if (kind_ff == rss_pkg::KIND_CLEAR) begin
                        head_ff <= NIL;
                        tail_ff <= NIL;
                        used_ff <= '0;
                     end
                  end
                  rss_pkg::KIND_TICK: begin
                     fin = 1'b0;
                     cn = cnt_ff;
                     if (run_ff && hvalid) begin
                        if (!expired) cn = cnt_ff - 1'b1;
                        else begin
                           cn = '0;
                           priority case (phase_ff)
                              rss_pkg::PH_HOLD, rss_pkg::PH_POLL: begin
                                 if (reached_w) fin = 1'b1;
                                 else begin
                                    phase_ff <= rss_pkg::PH_POLL;
                                    cn = {8'd0, poll_ff};
                                 end
                              end
                              rss_pkg::PH_RAMP: begin
                                 cn = period_ff[hi];
                                 if (sp_ff == stop_ff[hi]) phase_ff <= rss_pkg::PH_SETTLE;
                                 else if (err_ff <= $signed({1'b0, dev_ff})) begin
                                    sp_ff <= nsp_w;
                                    o_chg_ff <= 1'b1;
                                 end
                              end
                              rss_pkg::PH_SETTLE: begin
                                 cn = period_ff[hi];
                                 if (reached_w) fin = 1'b1;
                              end
                              default: ;
                           endcase
                        end
                     end
                     // segment done: free head and begin the next one, or end the program if none follows
                     if (fin) begin
                        nh = next_ff[hi];
                        done_ff <= done_ff + 1'b1;
                        last_ff <= ident_ff[hi];
                        valid_ff[hi] <= 1'b0;
                        busy_ff[hi] <= 1'b0;
                        next_ff[hi] <= NIL;
                        if (used_ff != '0) used_ff <= used_ff - 1'b1;
                        if (nh < NIL) begin
                           head_ff <= nh;
                           if (tail_ff == head_ff) tail_ff <= NIL;
                           busy_ff[nh[IW-1:0]] <= 1'b1;
                           sp_ff <= start_ff[nh[IW-1:0]];
                           o_chg_ff <= 1'b1;
                           o_start_ff <= 1'b1;
                           o_snum_ff <= ident_ff[nh[IW-1:0]];
                           cn = period_ff[nh[IW-1:0]];
                           phase_ff <= dyn_ff[nh[IW-1:0]] ? rss_pkg::PH_RAMP
                                                         : rss_pkg::PH_HOLD;
                        end else begin
                           head_ff <= NIL;
                           tail_ff <= NIL;
                           run_ff <= 1'b0;
                           phase_ff <= rss_pkg::PH_IDLE;
                           cn = '0;
                           o_done_ff <= 1'b1;
                        end
                     end
                     cnt_ff <= cn;
                  end
                  default: ;
               endcase
            end
            S_RESP: begin
               if (rsp_ready) fsm_ff <= S_IDLE;
            end
            default: fsm_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/rss_checker.sv =====
// port-level checker of the ramp/soak segment sequencer and its bind
module rss_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic        rsp_segment_started,
   input logic        rsp_program_done,
   input logic        rsp_running,
   input logic [15:0] rsp_started_number
);

   // one item in flight: never ready while a result waits
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");

   // a result is held until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");

   // program done means no longer running
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_program_done |-> !rsp_running) else $error("done but running");

   // a started segment means running and ok status
   a_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_segment_started |-> rsp_running && rsp_status == rss_pkg::ST_OK)
      else $error("start inconsistent");

   // no number without a start
   a_num: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_segment_started |-> rsp_started_number == 16'd0)
      else $error("stray started number");

endmodule

bind ramp_soak_segment_sequencer rss_checker u_rss_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
   .rsp_segment_started(rsp_segment_started), .rsp_program_done(rsp_program_done),
   .rsp_running(rsp_running), .rsp_started_number(rsp_started_number)
);
